[design/tpuc_pkg.sv]
// Shared types and constants for the packed pattern decoder.
package tpuc_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic       result_kind;
        logic [5:0] row_index;
        logic [4:0] channel_index;
        logic [6:0] note_out;
        logic [7:0] instrument_out;
        logic [7:0] volume_out;
        logic [5:0] effect_out;
        logic [7:0] effect_param_out;
        logic [4:0] highest_channel;
    } t_out_word;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_MASK  = 3'd0,
        PH_NOTE  = 3'd1,
        PH_INSTR = 3'd2,
        PH_VOL   = 3'd3,
        PH_EFX   = 3'd4,
        PH_PARAM = 3'd5
    } t_phase;

    localparam logic [1:0] CFG_MAX_INSTRUMENT = 2'd0;
    localparam logic [1:0] CFG_NOTE_OFF_CODE  = 2'd1;

    // Per-channel memory contents read for one cell.
    typedef struct packed {
        logic [7:0] last_param;
        logic [7:0] last_effect;
        logic [7:0] last_vib;
        logic [7:0] last_porta;
    } t_chan_mem;

    // Held cell fields presented to the converter.
    typedef struct packed {
        logic [4:0] channel;
        logic [7:0] mask;
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume;
        logic [7:0] effect;
        logic [7:0] param;
        logic [5:0] row;
        logic [4:0] highest;
    } t_cell;

    // Memory write-back from the converter.
    typedef struct packed {
        logic       we_param;
        logic       we_vib;
        logic       we_effect;
        logic       we_porta;
        logic [7:0] param;
        logic [7:0] effect;
        logic [7:0] porta;
    } t_mem_upd;

endpackage

[design/tpuc_convert.sv]
// Combinational cell conversion: note, volume, effect remapping and memory update.
module tpuc_convert (
    input  tpuc_pkg::t_cell     i_cell,
    input  tpuc_pkg::t_chan_mem i_mem,
    input  logic [7:0]          i_max_instrument,
    input  logic [6:0]          i_note_off_code,
    output tpuc_pkg::t_out_word o_word,
    output tpuc_pkg::t_mem_upd  o_upd
);
    import tpuc_pkg::*;

    logic [7:0] e;
    logic [7:0] d0;
    logic [7:0] d;
    logic [7:0] dm;
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] efx;
    logic       was_off;
    logic       fine;
    logic [3:0] hi;
    logic [8:0] note_calc;
    logic [8:0] dbl;

    always_comb begin
        e        = i_cell.effect;
        d0       = i_cell.param;
        note     = '0;
        ins      = '0;
        vol      = '0;
        efx      = '0;
        d        = '0;
        dm       = '0;
        was_off  = 1'b0;
        fine     = 1'b0;
        hi       = '0;
        dbl      = '0;
        note_calc = 9'd1 + {5'd0, i_cell.note[3:0]} + ({5'd0, i_cell.note[7:4]} * 9'd12);
        o_upd    = '0;

        // Note and instrument.
        if (i_cell.mask[5]) begin
            ins = (i_cell.instrument > i_max_instrument) ? 8'd0 : i_cell.instrument;
            if (i_cell.note == 8'd254) begin
                note    = {1'b0, i_note_off_code};
                was_off = 1'b1;
            end else if (i_cell.note == 8'd255) begin
                note = '0;
            end else begin
                note = (note_calc > 9'd96) ? 8'd0 : note_calc[7:0];
            end
        end
        // Volume column.
        if (i_cell.mask[6]) begin
            vol = (i_cell.volume <= 8'd64) ? i_cell.volume + 8'h10 : 8'd0;
        end
        // Effect with parameter memory.
        if (i_cell.mask[7]) begin
            efx = e;
            d   = d0;
            if (d0 != 8'd0) begin
                o_upd.we_param = 1'b1;
                o_upd.we_vib   = (e == 8'd8) || (e == 8'd21);
            end
            if (d0 == 8'd0 && e != 8'd7) begin
                if (e == 8'd8 || e == 8'd21) begin
                    dm = i_mem.last_vib;
                end else if ((e >= 8'd4 && e <= 8'd12) || (e >= 8'd17 && e <= 8'd19)) begin
                    dm = i_mem.last_param;
                end else begin
                    dm = 8'd0;
                end
                fine = (((e == 8'd5) || (e == 8'd6))
                        && ((dm[7:4] == 4'hF) || (dm[7:4] == 4'hE)))
                    || (((e == 8'd4) || (e == 8'd11))
                        && ((dm > 8'hF0) || ((dm[3:0] == 4'hF) && (dm[7:4] != 4'h0))));
                d = dm;
                if (e == i_mem.last_effect && e != 8'd10 && e != 8'd19 && !fine) begin
                    d = 8'd0;
                end
            end
            o_upd.we_effect = (e != 8'd0);

            case (e)
                8'd1: begin
                    efx = 8'h0F;
                    if (d == 8'd0) efx = 8'd0;
                    else if (d > 8'h1F) d = 8'h1F;
                end
                8'd2: efx = 8'h0B;
                8'd3: efx = 8'h0D;
                8'd4, 8'd11: begin
                    if (d > 8'hF0) begin
                        efx = 8'h0E;
                        d   = {4'hB, d[3:0]};
                        if (e == 8'd11 && vol == 8'd0) vol = 8'hB0;
                    end else if (d[3:0] == 4'hF && d[7:4] != 4'h0) begin
                        efx = 8'h0E;
                        d   = {4'hA, d[7:4]};
                        if (e == 8'd11 && vol == 8'd0) vol = 8'hB0;
                    end else begin
                        efx = (e == 8'd4) ? 8'h0A : 8'd6;
                        if (d[3:0] != 4'h0) d = {4'h0, d[3:0]};
                    end
                end
                8'd5, 8'd6: begin
                    if (d[7:4] >= 4'hE) begin
                        efx = (d[7:4] == 4'hE) ? 8'h21 : 8'h0E;
                        d   = {4'h0, d[3:0]} | ((e == 8'd5) ? 8'h20 : 8'h10);
                    end else begin
                        efx = 8'd7 - e;
                    end
                end
                8'd7: begin
                    efx = 8'd3;
                    if (ins != 8'd0 && ins != i_mem.last_porta) ins = i_mem.last_porta;
                end
                8'd8:  efx = 8'h04;
                8'd9:  efx = 8'h1D;
                8'd10: efx = 8'h00;
                8'd12: efx = 8'h05;
                8'd15: efx = 8'h09;
                8'd17: efx = 8'h1B;
                8'd18: efx = 8'h07;
                8'd19: begin
                    hi  = d[7:4];
                    efx = 8'h0E;
                    d   = {4'h0, d[3:0]};
                    case (hi)
                        4'h1: d = d | 8'h30;
                        4'h2: d = d | 8'h50;
                        4'h3: d = d | 8'h40;
                        4'h4: d = d | 8'h70;
                        4'h8: begin
                            efx = 8'd8;
                            d   = {d[3:0], d[3:0]};
                        end
                        4'hB: d = d | 8'h60;
                        4'hC: begin
                            d = d | 8'hC0;
                            if (d == 8'hC0) begin
                                efx = 8'd0;
                                d   = 8'd0;
                            end
                        end
                        4'hD: begin
                            d = d | 8'hD0;
                            if (note == 8'd0 || was_off) begin
                                efx = 8'd0;
                                d   = 8'd0;
                            end else if (d == 8'hD0) begin
                                note = 8'd0;
                                ins  = 8'd0;
                                vol  = 8'd0;
                                efx  = 8'd0;
                                d    = 8'd0;
                            end
                        end
                        4'hE: d = d | 8'hE0;
                        4'hF: d = d | 8'hF0;
                        default: begin
                            efx = 8'd0;
                            d   = 8'd0;
                        end
                    endcase
                end
                8'd20: begin
                    efx = 8'h0F;
                    if (d < 8'h21) begin
                        efx = 8'd0;
                        d   = 8'd0;
                    end
                end
                8'd22: begin
                    if (d > 8'h40) begin
                        efx = 8'd0;
                        d   = 8'd0;
                    end else begin
                        efx = 8'h10;
                    end
                end
                8'd24: begin
                    if (d > 8'h80) begin
                        efx = 8'd0;
                        d   = 8'd0;
                    end else begin
                        efx = 8'd8;
                        dbl = {d, 1'b0};
                        d   = (dbl > 9'd255) ? 8'd255 : dbl[7:0];
                    end
                end
                default: begin
                    efx = 8'd0;
                    d   = 8'd0;
                end
            endcase
        end
        o_upd.we_porta = (ins != 8'd0) && (efx != 8'd3);
        o_upd.param    = d0;
        o_upd.effect   = e;
        o_upd.porta    = ins;

        o_word.result_kind      = 1'b0;
        o_word.row_index        = i_cell.row;
        o_word.channel_index    = i_cell.channel;
        o_word.note_out         = note[6:0];
        o_word.instrument_out   = ins;
        o_word.volume_out       = vol;
        o_word.effect_out       = efx[5:0];
        o_word.effect_param_out = d;
        o_word.highest_channel  = i_cell.highest;
    end

endmodule

[design/tracker_pattern_unpack_convert.sv]
// Top level of the packed pattern decoder: parser, channel memories and result register.
// Words that complete a cell or end the pattern give registered results. One word per cycle
// while o_stall is low; the only loop is a single channel memory read-modify-write.
// The result register is a two-entry skid stage, so input is taken while a result waits.
// Reset (synchronous, active low) clears parse state, row count, highest channel,
// configuration registers to defaults and the per-channel memory valid bits.
module tracker_pattern_unpack_convert #(
    parameter int NUM_CHANNELS     = 32,
    parameter int ROWS_PER_PATTERN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tpuc_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output tpuc_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import tpuc_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [7:0]  r_max_ins;
    logic [6:0]  r_off_code;
    t_phase      r_phase;
    logic [7:0]  r_mask, r_note, r_ins, r_vol, r_efx;
    logic [4:0]  r_chan;
    logic [6:0]  r_row;
    logic        r_done;
    logic [4:0]  r_high;
    logic [NUM_CHANNELS-1:0] r_mvalid;
    logic [7:0]  r_m_param  [NUM_CHANNELS];
    logic [7:0]  r_m_effect [NUM_CHANNELS];
    logic [7:0]  r_m_vib    [NUM_CHANNELS];
    logic [7:0]  r_m_porta  [NUM_CHANNELS];

    // Output skid: main and spare entry.
    logic        r_ov, r_sv;
    t_out_word   r_od, r_sd;

    logic        acc;
    logic        start;
    logic [7:0]  b;
    t_phase      n_phase;
    logic [7:0]  n_mask, n_note, n_ins, n_vol, n_efx;
    logic [4:0]  n_chan;
    logic [4:0]  n_high;
    logic        emit_cell, emit_end;
    logic        chan_ok;
    logic [7:0]  row_inc;
    t_cell       held_cell;
    t_chan_mem   mem_rd;
    t_out_word   cell_word, res_word;
    t_mem_upd    upd;
    logic [CW-1:0] ci;

    assign o_stall = r_sv;
    assign acc     = i_valid && !o_stall;
    assign start   = i_data.req_type;
    assign b       = i_data.data_byte;
    assign row_inc = {1'b0, r_row} + 8'd1;

    // Phase sequencing and field capture.
    always_comb begin
        n_phase   = r_phase;
        n_mask    = r_mask;
        n_chan    = r_chan;
        n_note    = r_note;
        n_ins     = r_ins;
        n_vol     = r_vol;
        n_efx     = r_efx;
        n_high    = r_high;
        emit_cell = 1'b0;
        emit_end  = 1'b0;
        case (r_phase)
            PH_MASK: begin
                if (b == 8'd0) begin
                    emit_end = (row_inc >= 8'(ROWS_PER_PATTERN));
                end else begin
                    n_mask = b;
                    n_chan = b[4:0];
                    if ({3'd0, b[4:0]} < 8'(NUM_CHANNELS) && b[4:0] > r_high) n_high = b[4:0];
                    if (b[5])      n_phase = PH_NOTE;
                    else if (b[6]) n_phase = PH_VOL;
                    else if (b[7]) n_phase = PH_EFX;
                    else           n_phase = PH_MASK;
                end
            end
            PH_NOTE: begin
                n_note  = b;
                n_phase = PH_INSTR;
            end
            PH_INSTR: begin
                n_ins = b;
                if (r_mask[6])      n_phase = PH_VOL;
                else if (r_mask[7]) n_phase = PH_EFX;
                else                n_phase = PH_MASK;
            end
            PH_VOL: begin
                n_vol   = b;
                n_phase = r_mask[7] ? PH_EFX : PH_MASK;
            end
            PH_EFX: begin
                n_efx   = b;
                n_phase = PH_PARAM;
            end
            PH_PARAM: n_phase = PH_MASK;
            default:  n_phase = PH_MASK;
        endcase
        chan_ok   = ({3'd0, n_chan} < 8'(NUM_CHANNELS));
        emit_cell = (n_phase == PH_MASK) && !(r_phase == PH_MASK && b == 8'd0) && chan_ok;
    end

    // Channel memory read; entries not written since start read as zero.
    assign ci = n_chan[CW-1:0];
    always_comb begin
        if (r_mvalid[ci]) begin
            mem_rd.last_param  = r_m_param[ci];
            mem_rd.last_effect = r_m_effect[ci];
            mem_rd.last_vib    = r_m_vib[ci];
            mem_rd.last_porta  = r_m_porta[ci];
        end else begin
            mem_rd = '0;
        end
        held_cell.channel    = n_chan;
        held_cell.mask       = n_mask;
        held_cell.note       = n_note;
        held_cell.instrument = n_ins;
        held_cell.volume     = n_vol;
        held_cell.effect     = n_efx;
        held_cell.param      = b;
        held_cell.row        = r_row[5:0];
        held_cell.highest    = n_high;
    end

    tpuc_convert u_conv (
        .i_cell           (held_cell),
        .i_mem            (mem_rd),
        .i_max_instrument (r_max_ins),
        .i_note_off_code  (r_off_code),
        .o_word           (cell_word),
        .o_upd            (upd)
    );

    always_comb begin
        if (emit_end) begin
            res_word                 = '0;
            res_word.result_kind     = 1'b1;
            res_word.highest_channel = r_high;
        end else begin
            res_word = cell_word;
        end
    end

    // Configuration, parser state and memories.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ins  <= 8'd128;
            r_off_code <= 7'd97;
            r_phase    <= PH_MASK;
            r_mask     <= '0;
            r_chan     <= '0;
            r_note     <= '0;
            r_ins      <= '0;
            r_vol      <= '0;
            r_efx      <= '0;
            r_row      <= '0;
            r_done     <= 1'b0;
            r_high     <= '0;
            r_mvalid   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_INSTRUMENT[0:0]: r_max_ins  <= i_cfg_data;
                    CFG_NOTE_OFF_CODE[0:0]:  r_off_code <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (acc) begin
                if (start) begin
                    r_phase  <= PH_MASK;
                    r_mask   <= '0;
                    r_chan   <= '0;
                    r_note   <= '0;
                    r_ins    <= '0;
                    r_vol    <= '0;
                    r_efx    <= '0;
                    r_row    <= '0;
                    r_done   <= 1'b0;
                    r_mvalid <= '0;
                end else if (!r_done) begin
                    r_phase <= n_phase;
                    r_mask  <= n_mask;
                    r_chan  <= n_chan;
                    r_note  <= n_note;
                    r_ins   <= n_ins;
                    r_vol   <= n_vol;
                    r_efx   <= n_efx;
                    r_high  <= n_high;
                    if (r_phase == PH_MASK && b == 8'd0) begin
                        r_row <= row_inc[6:0];
                        if (emit_end) r_done <= 1'b1;
                    end
                    if (emit_cell) begin
                        r_mvalid[ci] <= 1'b1;
                    end
                end
            end
        end
    end

    // Memory data, merged with read value so a fresh entry starts from zero.
    always_ff @(posedge i_clk) begin
        if (acc && !start && !r_done && emit_cell) begin
            r_m_param[ci]  <= upd.we_param  ? upd.param  : mem_rd.last_param;
            r_m_vib[ci]    <= upd.we_vib    ? upd.param  : mem_rd.last_vib;
            r_m_effect[ci] <= upd.we_effect ? upd.effect : mem_rd.last_effect;
            r_m_porta[ci]  <= upd.we_porta  ? upd.porta  : mem_rd.last_porta;
        end
    end

    // Result skid register.
    logic push;
    assign push = acc && !start && !r_done && (emit_cell || emit_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || !i_stall) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= push;
                end
            end else if (push) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_od <= r_sv ? r_sd : res_word;
        end
        if (push && r_ov && i_stall) begin
            r_sd <= res_word;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    // A finished pattern keeps its row count.
    a_done_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && !(acc && start) |=> r_done && $stable(r_row))
        else $error("row count moved after pattern end");
    // The spare entry is only used while the main entry is full.
    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("spare result without main result");
    // Cell and pattern end never coincide.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit_end && emit_cell))
        else $error("cell and pattern end at once");

endmodule
